// ===== design/tcm_pkg.sv =====
// Shared types and codes for the terminal cursor and margin unit.
// Used by tcm_cmd_exec and terminal_cursor_margin_unit; no dependencies.
package tcm_pkg;

    localparam int unsigned CfgIdxW = 2;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SCREEN_ROWS = 2'd0,
        CFG_SCREEN_COLS = 2'd1
    } cfg_index_t;

    typedef enum logic [4:0] {
        MODE_UP           = 5'd0,
        MODE_DOWN         = 5'd1,
        MODE_FORWARD      = 5'd2,
        MODE_BACK         = 5'd3,
        MODE_ADDRESS      = 5'd4,
        MODE_MARGINS      = 5'd5,
        MODE_REV_INDEX    = 5'd6,
        MODE_INDEX        = 5'd7,
        MODE_NEXT_LINE    = 5'd8,
        MODE_SAVE         = 5'd9,
        MODE_RESTORE      = 5'd10,
        MODE_ORIGIN_ON    = 5'd11,
        MODE_ORIGIN_OFF   = 5'd12,
        MODE_SOFT_RESET   = 5'd13,
        MODE_FULL_RESET   = 5'd14,
        MODE_HOME         = 5'd15,
        MODE_SCROLL_UP    = 5'd16,
        MODE_SCROLL_DOWN  = 5'd17
    } mode_t;

    localparam logic [1:0] SCROLL_NONE = 2'd0;
    localparam logic [1:0] SCROLL_UP   = 2'd1;
    localparam logic [1:0] SCROLL_DOWN = 2'd2;

    localparam logic [7:0] ROWS_RESET = 8'd25;
    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [7:0] DIM_MIN    = 8'd2;

    typedef struct packed {
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] top;
        logic [7:0] bottom;
        logic       origin;
        logic       saved_valid;
        logic [7:0] saved_row;
        logic [7:0] saved_col;
        logic       saved_origin;
    } cursor_state_t;

    typedef struct packed {
        logic [7:0]  row;
        logic [7:0]  col;
        logic [15:0] linear;
        logic [1:0]  dir;
        logic [7:0]  lines;
        logic [7:0]  top;
        logic [7:0]  bottom;
    } result_t;

endpackage

// ===== design/tcm_cmd_exec.sv =====
// Command execution logic: applies one decoded command to the cursor state.
// Produces the next state and the result beat. Depends on tcm_pkg.
module tcm_cmd_exec (
    input  tcm_pkg::cursor_state_t state,
    input  logic [4:0]             mode,
    input  logic [15:0]            param_first,
    input  logic [15:0]            param_second,
    input  logic [7:0]             rows_eff,
    input  logic [7:0]             cols_eff,
    output tcm_pkg::cursor_state_t state_next,
    output tcm_pkg::result_t       result
);
    import tcm_pkg::*;

    function automatic logic [7:0] count_of(input logic [15:0] p, input logic [7:0] limit);
        logic [15:0] n;
        n = (p == 16'd0) ? 16'd1 : p;
        return (n > {8'd0, limit}) ? limit : n[7:0];
    endfunction

    function automatic logic [7:0] clamp_range(input logic [15:0] v, input logic [7:0] lo,
                                               input logic [7:0] hi);
        logic [7:0] r;
        if (v < {8'd0, lo})
            r = lo;
        else if (v > {8'd0, hi})
            r = hi;
        else
            r = v[7:0];
        return r;
    endfunction

    cursor_state_t s;
    logic [1:0]    dir;
    logic [7:0]    lines;
    logic [7:0]    lim;
    logic [7:0]    height;
    logic [7:0]    r_clamp;
    logic [7:0]    c_clamp;
    logic [15:0]   t_raw;
    logic [15:0]   b_raw;
    logic [7:0]    t_clamp;
    logic [7:0]    b_clamp;
    logic [7:0]    last_row;
    logic [7:0]    last_col;
    logic [15:0]   row_times_cols;

    assign last_row = rows_eff - 8'd1;
    assign last_col = cols_eff - 8'd1;

    always_comb
    begin
        s       = state;
        dir     = SCROLL_NONE;
        lines   = 8'd0;
        lim     = 8'd0;
        height  = state.origin ? (state.bottom - state.top + 8'd1) : rows_eff;
        r_clamp = clamp_range(param_first, 8'd1, height);
        c_clamp = clamp_range(param_second, 8'd1, cols_eff);
        t_raw   = (param_first == 16'd0) ? 16'd1 : param_first;
        b_raw   = (param_second == 16'd0) ? {8'd0, rows_eff} : param_second;
        t_clamp = clamp_range(t_raw, 8'd1, last_row);
        b_clamp = clamp_range(b_raw, DIM_MIN, rows_eff);
        case (mode_t'(mode))
            MODE_UP:
            begin
                lim   = (state.row > state.top) ? (state.row - state.top) : 8'd0;
                s.row = state.row - count_of(param_first, lim);
            end
            MODE_DOWN:
            begin
                lim   = (state.bottom > state.row) ? (state.bottom - state.row) : 8'd0;
                s.row = state.row + count_of(param_first, lim);
            end
            MODE_FORWARD:
            begin
                lim   = (last_col > state.col) ? (last_col - state.col) : 8'd0;
                s.col = state.col + count_of(param_first, lim);
            end
            MODE_BACK:
            begin
                s.col = state.col - count_of(param_first, state.col);
            end
            MODE_ADDRESS:
            begin
                if (param_first == 16'd0 && param_second == 16'd0)
                begin
                    s.row = state.origin ? state.top : 8'd0;
                    s.col = 8'd0;
                end
                else
                begin
                    s.row = r_clamp - 8'd1 + (state.origin ? state.top : 8'd0);
                    s.col = c_clamp - 8'd1;
                end
            end
            MODE_MARGINS:
            begin
                if (b_raw > t_raw)
                begin
                    s.top    = t_clamp - 8'd1;
                    s.bottom = b_clamp - 8'd1;
                    s.row    = state.origin ? (t_clamp - 8'd1) : 8'd0;
                    s.col    = 8'd0;
                end
            end
            MODE_REV_INDEX:
            begin
                if (state.row == state.top)
                begin
                    dir   = SCROLL_DOWN;
                    lines = 8'd1;
                end
                else if (state.row > 8'd0)
                    s.row = state.row - 8'd1;
            end
            MODE_INDEX, MODE_NEXT_LINE:
            begin
                if (state.row == state.bottom)
                begin
                    dir   = SCROLL_UP;
                    lines = 8'd1;
                end
                else if (state.row < last_row)
                    s.row = state.row + 8'd1;
                if (mode_t'(mode) == MODE_NEXT_LINE)
                    s.col = 8'd0;
            end
            MODE_SAVE:
            begin
                s.saved_row    = state.row;
                s.saved_col    = state.col;
                s.saved_origin = state.origin;
                s.saved_valid  = 1'b1;
            end
            MODE_RESTORE:
            begin
                if (state.saved_valid)
                begin
                    s.row         = state.saved_row;
                    s.col         = state.saved_col;
                    s.origin      = state.saved_origin;
                    s.saved_valid = 1'b0;
                end
            end
            MODE_ORIGIN_ON:
            begin
                s.origin = 1'b1;
                s.row    = state.top;
                s.col    = 8'd0;
            end
            MODE_ORIGIN_OFF:
            begin
                s.origin = 1'b0;
                s.row    = 8'd0;
                s.col    = 8'd0;
            end
            MODE_SOFT_RESET:
            begin
                s.top         = 8'd0;
                s.bottom      = last_row;
                s.origin      = 1'b0;
                s.saved_valid = 1'b0;
            end
            MODE_FULL_RESET:
            begin
                s.row         = 8'd0;
                s.col         = 8'd0;
                s.top         = 8'd0;
                s.bottom      = last_row;
                s.origin      = 1'b0;
                s.saved_valid = 1'b0;
            end
            MODE_HOME:
            begin
                s.row = 8'd0;
                s.col = 8'd0;
            end
            MODE_SCROLL_UP:
            begin
                dir   = SCROLL_UP;
                lines = count_of(param_first, last_row);
            end
            MODE_SCROLL_DOWN:
            begin
                dir   = SCROLL_DOWN;
                lines = count_of(param_first, last_row);
            end
            default:
            begin
                s = state;
            end
        endcase
    end

    assign row_times_cols = s.row * cols_eff;
    assign state_next     = s;

    always_comb
    begin
        result.row    = s.row;
        result.col    = s.col;
        result.linear = row_times_cols + {8'd0, s.col};
        result.dir    = dir;
        result.lines  = lines;
        result.top    = s.top;
        result.bottom = s.bottom;
    end

endmodule

// ===== design/terminal_cursor_margin_unit.sv =====
// Top level of the terminal cursor and margin unit: input and result registers,
// cursor state, screen size registers. Depends on tcm_pkg and tcm_cmd_exec.

// One command per cycle: a command beat is held in the input register, executed
// against the cursor state in a single pass and lands in the result register;
// a new command is taken every cycle while the result side keeps up. The result
// register and the input register let the input side take one more command
// while one result waits. Screen size writes are applied at once; margins return
// to the full screen on a row count write and the cursor is pulled inside the
// screen.
module terminal_cursor_margin_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [tcm_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [7:0]                  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [4:0]                  mode,
    input  logic [15:0]                 param_first,
    input  logic [15:0]                 param_second,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  cursor_row,
    output logic [7:0]                  cursor_col,
    output logic [15:0]                 cursor_linear,
    output logic [1:0]                  scroll_dir,
    output logic [7:0]                  scroll_lines,
    output logic [7:0]                  region_top,
    output logic [7:0]                  region_bottom
);
    import tcm_pkg::*;

    localparam cursor_state_t STATE_RESET = '{
        row:          8'd0,
        col:          8'd0,
        top:          8'd0,
        bottom:       ROWS_RESET - 8'd1,
        origin:       1'b0,
        saved_valid:  1'b0,
        saved_row:    8'd0,
        saved_col:    8'd0,
        saved_origin: 1'b0
    };

    logic          cmd_valid_reg;
    logic [4:0]    mode_reg;
    logic [15:0]   param_first_reg;
    logic [15:0]   param_second_reg;
    logic [7:0]    rows_reg;
    logic [7:0]    cols_reg;
    logic [7:0]    rows_eff;
    logic [7:0]    cols_eff;
    logic [7:0]    cfg_eff;
    cursor_state_t state_reg;
    cursor_state_t state_next;
    cursor_state_t exec_next;
    result_t       exec_result;
    result_t       result_reg;
    logic          out_valid_reg;
    logic          advance;
    logic          accept;

    assign rows_eff = (rows_reg < DIM_MIN) ? DIM_MIN : rows_reg;
    assign cols_eff = (cols_reg < DIM_MIN) ? DIM_MIN : cols_reg;
    assign cfg_eff  = (cfg_data < DIM_MIN) ? DIM_MIN : cfg_data;

    assign advance  = cmd_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = cmd_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    tcm_cmd_exec u_exec (
        .state        (state_reg),
        .mode         (mode_reg),
        .param_first  (param_first_reg),
        .param_second (param_second_reg),
        .rows_eff     (rows_eff),
        .cols_eff     (cols_eff),
        .state_next   (exec_next),
        .result       (exec_result)
    );

    always_comb
    begin
        state_next = state_reg;
        if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SCREEN_ROWS:
                begin
                    state_next.top    = 8'd0;
                    state_next.bottom = cfg_eff - 8'd1;
                    if (state_reg.row > cfg_eff - 8'd1)
                        state_next.row = cfg_eff - 8'd1;
                    if (state_reg.saved_row > cfg_eff - 8'd1)
                        state_next.saved_row = cfg_eff - 8'd1;
                end
                CFG_SCREEN_COLS:
                begin
                    if (state_reg.col > cfg_eff - 8'd1)
                        state_next.col = cfg_eff - 8'd1;
                    if (state_reg.saved_col > cfg_eff - 8'd1)
                        state_next.saved_col = cfg_eff - 8'd1;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
        else if (advance)
            state_next = exec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg                 <= ROWS_RESET;
            cols_reg                 <= COLS_RESET;
            state_reg                <= STATE_RESET;
            cmd_valid_reg            <= 1'b0;
            out_valid_reg            <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write && cfg_index_t'(cfg_index) == CFG_SCREEN_ROWS)
                rows_reg <= cfg_data;
            if (cfg_write && cfg_index_t'(cfg_index) == CFG_SCREEN_COLS)
                cols_reg <= cfg_data;
            if (accept)
                cmd_valid_reg <= 1'b1;
            else if (advance)
                cmd_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // hold the command and result payloads until their beats move
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg         <= mode;
            param_first_reg  <= param_first;
            param_second_reg <= param_second;
        end
        if (advance)
            result_reg <= exec_result;
    end

    assign out_valid     = out_valid_reg;
    assign cursor_row    = result_reg.row;
    assign cursor_col    = result_reg.col;
    assign cursor_linear = result_reg.linear;
    assign scroll_dir    = result_reg.dir;
    assign scroll_lines  = result_reg.lines;
    assign region_top    = result_reg.top;
    assign region_bottom = result_reg.bottom;

    a_margin_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.top < state_reg.bottom && state_reg.bottom < rows_eff)
        else $error("scroll region out of order");

    a_cursor_inside: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.row < rows_eff && state_reg.col < cols_eff)
        else $error("cursor outside the screen");

    a_no_lines_without_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.dir == SCROLL_NONE |-> result_reg.lines == 8'd0)
        else $error("scroll lines without scroll request");

    a_empty_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_valid_reg |-> !in_stall)
        else $error("input stalled with empty command register");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("executed command lost");

endmodule

// ===== tb/terminal_cursor_margin_unit_test.sv =====
`timescale 1ns / 100ps
// Testbench for terminal_cursor_margin_unit: directed and random cursor commands
// checked beat by beat against a cursor predictor kept in a scoreboard class.
// Depends on tcm_pkg and the terminal_cursor_margin_unit RTL only.

module terminal_cursor_margin_unit_test;
    import tcm_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int HOLD_CYCLES      = 150;
    localparam int PHASE_COUNT      = 6;
    localparam int PHASE_ROWS [PHASE_COUNT] = '{25, 2, 255, 2, 255, 0};
    localparam int PHASE_COLS [PHASE_COUNT] = '{80, 2, 255, 255, 2, 0};

    class cursor_scoreboard;
        logic [7:0] rows_cfg;
        logic [7:0] cols_cfg;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] top;
        logic [7:0] bottom;
        logic       origin;
        logic       saved_valid;
        logic [7:0] saved_row;
        logic [7:0] saved_col;
        logic       saved_origin;
        result_t    expected_positions[$];
        int         errors;

        function new();
            rows_cfg = ROWS_RESET;
            cols_cfg = COLS_RESET;
            row = 0;
            col = 0;
            saved_row = 0;
            saved_col = 0;
            saved_origin = 0;
            errors = 0;
            full_screen_region();
        endfunction

        function int unsigned rows_in_use();
            return (rows_cfg < DIM_MIN) ? DIM_MIN : rows_cfg;
        endfunction

        function int unsigned cols_in_use();
            return (cols_cfg < DIM_MIN) ? DIM_MIN : cols_cfg;
        endfunction

        function void full_screen_region();
            top = 0;
            bottom = 8'(rows_in_use() - 1);
            origin = 0;
            saved_valid = 0;
        endfunction

        function int unsigned step_count(int unsigned p, int unsigned limit);
            int unsigned n;
            n = (p < 1) ? 1 : p;
            return (n > limit) ? limit : n;
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo)
            begin
                return lo;
            end
            if (v > hi)
            begin
                return hi;
            end
            return v;
        endfunction

        function int pending_count();
            return expected_positions.size();
        endfunction

        function void apply_reg(cfg_index_t idx, logic [7:0] value);
            if (idx == CFG_SCREEN_ROWS)
            begin
                rows_cfg = value;
                top = 0;
                bottom = 8'(rows_in_use() - 1);
                if (row > rows_in_use() - 1)
                begin
                    row = 8'(rows_in_use() - 1);
                end
                if (saved_row > rows_in_use() - 1)
                begin
                    saved_row = 8'(rows_in_use() - 1);
                end
            end
            else if (idx == CFG_SCREEN_COLS)
            begin
                cols_cfg = value;
                if (col > cols_in_use() - 1)
                begin
                    col = 8'(cols_in_use() - 1);
                end
                if (saved_col > cols_in_use() - 1)
                begin
                    saved_col = 8'(cols_in_use() - 1);
                end
            end
        endfunction

        function void note_command(logic [4:0] m, logic [15:0] p, logic [15:0] q);
            int unsigned rows_n;
            int unsigned cols_n;
            int unsigned lim;
            int unsigned t;
            int unsigned b;
            int unsigned h;
            result_t     want;
            rows_n = rows_in_use();
            cols_n = cols_in_use();
            want.dir = SCROLL_NONE;
            want.lines = 0;
            case (m)
                MODE_UP:
                begin
                    lim = (row > top) ? row - top : 0;
                    row = 8'(row - step_count(p, lim));
                end
                MODE_DOWN:
                begin
                    lim = (bottom > row) ? bottom - row : 0;
                    row = 8'(row + step_count(p, lim));
                end
                MODE_FORWARD:
                begin
                    lim = (cols_n - 1 > col) ? cols_n - 1 - col : 0;
                    col = 8'(col + step_count(p, lim));
                end
                MODE_BACK:
                begin
                    col = 8'(col - step_count(p, col));
                end
                MODE_ADDRESS:
                begin
                    if (p == 0 && q == 0)
                    begin
                        row = origin ? top : 8'd0;
                        col = 0;
                    end
                    else
                    begin
                        h = origin ? bottom - top + 1 : rows_n;
                        row = 8'(clamp(p, 1, h) - 1 + (origin ? top : 0));
                        col = 8'(clamp(q, 1, cols_n) - 1);
                    end
                end
                MODE_MARGINS:
                begin
                    t = (p == 0) ? 1 : p;
                    b = (q == 0) ? rows_n : q;
                    if (b > t)
                    begin
                        top = 8'(clamp(t, 1, rows_n - 1) - 1);
                        bottom = 8'(clamp(b, 2, rows_n) - 1);
                        row = origin ? top : 8'd0;
                        col = 0;
                    end
                end
                MODE_REV_INDEX:
                begin
                    if (row == top)
                    begin
                        want.dir = SCROLL_DOWN;
                        want.lines = 1;
                    end
                    else if (row > 0)
                    begin
                        row = row - 1;
                    end
                end
                MODE_INDEX, MODE_NEXT_LINE:
                begin
                    if (row == bottom)
                    begin
                        want.dir = SCROLL_UP;
                        want.lines = 1;
                    end
                    else if (row < rows_n - 1)
                    begin
                        row = row + 1;
                    end
                    if (m == MODE_NEXT_LINE)
                    begin
                        col = 0;
                    end
                end
                MODE_SAVE:
                begin
                    saved_row = row;
                    saved_col = col;
                    saved_origin = origin;
                    saved_valid = 1;
                end
                MODE_RESTORE:
                begin
                    if (saved_valid)
                    begin
                        row = saved_row;
                        col = saved_col;
                        origin = saved_origin;
                        saved_valid = 0;
                    end
                end
                MODE_ORIGIN_ON:
                begin
                    origin = 1;
                    row = top;
                    col = 0;
                end
                MODE_ORIGIN_OFF:
                begin
                    origin = 0;
                    row = 0;
                    col = 0;
                end
                MODE_SOFT_RESET:
                begin
                    full_screen_region();
                end
                MODE_FULL_RESET:
                begin
                    row = 0;
                    col = 0;
                    full_screen_region();
                end
                MODE_HOME:
                begin
                    row = 0;
                    col = 0;
                end
                MODE_SCROLL_UP:
                begin
                    want.dir = SCROLL_UP;
                    want.lines = 8'(step_count(p, rows_n - 1));
                end
                MODE_SCROLL_DOWN:
                begin
                    want.dir = SCROLL_DOWN;
                    want.lines = 8'(step_count(p, rows_n - 1));
                end
                default:
                begin
                end
            endcase
            want.row = row;
            want.col = col;
            want.linear = 16'(row * cols_n + col);
            want.top = top;
            want.bottom = bottom;
            expected_positions.push_back(want);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_positions.size() == 0)
            begin
                $error("result beat with nothing expected: row %0d col %0d", got.row, got.col);
                errors++;
                return;
            end
            want = expected_positions.pop_front();
            compare_field("cursor_row", want.row, got.row);
            compare_field("cursor_col", want.col, got.col);
            compare_field("cursor_linear", want.linear, got.linear);
            compare_field("scroll_dir", want.dir, got.dir);
            compare_field("scroll_lines", want.lines, got.lines);
            compare_field("region_top", want.top, got.top);
            compare_field("region_bottom", want.bottom, got.bottom);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [7:0]          cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [4:0]          mode = '0;
    logic [15:0]         param_first = '0;
    logic [15:0]         param_second = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [7:0]          cursor_row;
    logic [7:0]          cursor_col;
    logic [15:0]         cursor_linear;
    logic [1:0]          scroll_dir;
    logic [7:0]          scroll_lines;
    logic [7:0]          region_top;
    logic [7:0]          region_bottom;

    cursor_scoreboard sb = new();
    int  cycles = 0;
    bit  hold_req = 1'b0;
    bit  rx_throttle = 1'b1;
    bit  tx_steady = 1'b0;

    terminal_cursor_margin_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .param_first   (param_first),
        .param_second  (param_second),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cursor_row    (cursor_row),
        .cursor_col    (cursor_col),
        .cursor_linear (cursor_linear),
        .scroll_dir    (scroll_dir),
        .scroll_lines  (scroll_lines),
        .region_top    (region_top),
        .region_bottom (region_bottom)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("terminal_cursor_margin_unit_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // result side: check each beat, stall in random runs, run steady or hold off on request
    initial
    begin
        int  hold_left;
        int  run_left;
        bit  stalling;
        bit  stall_next;
        result_t got;
        hold_left = 0;
        run_left = 0;
        stalling = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.row = cursor_row;
                got.col = cursor_col;
                got.linear = cursor_linear;
                got.dir = scroll_dir;
                got.lines = scroll_lines;
                got.top = region_top;
                got.bottom = region_bottom;
                sb.check_result(got);
            end
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (!rx_throttle)
            begin
                stall_next = 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    stalling = !stalling;
                    run_left = stalling ? $urandom_range(1, 5) : $urandom_range(1, 12);
                end
                run_left--;
                stall_next = stalling;
            end
            out_stall <= stall_next;
        end
    end

    task automatic send_cmd(logic [4:0] m, logic [15:0] p, logic [15:0] q);
        in_valid <= 1'b1;
        mode <= m;
        param_first <= p;
        param_second <= q;
        do @(posedge clk); while (in_stall);
        sb.note_command(m, p, q);
    endtask

    task automatic idle_sender(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_count() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [7:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        sb.apply_reg(idx, value);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_param(int unsigned dim);
        case ($urandom_range(0, 9))
            0: return 16'd0;
            7, 8: return 16'($urandom_range(0, 15));
            9: return 16'($urandom);
            default: return 16'($urandom_range(0, dim + 1));
        endcase
    endfunction

    task automatic issue_random();
        int unsigned pick;
        logic [4:0]  m;
        logic [15:0] p;
        logic [15:0] q;
        pick = $urandom_range(0, 23);
        if (pick < 18)
        begin
            m = 5'(pick);
        end
        else if (pick < 20)
        begin
            m = (pick == 18) ? MODE_INDEX : MODE_REV_INDEX;
        end
        else if (pick < 22)
        begin
            m = (pick == 20) ? MODE_MARGINS : MODE_ADDRESS;
        end
        else
        begin
            m = 5'($urandom_range(18, 31));
        end
        p = rand_param((m == MODE_FORWARD || m == MODE_BACK) ? sb.cols_in_use()
                                                             : sb.rows_in_use());
        q = rand_param((m == MODE_MARGINS) ? sb.rows_in_use() : sb.cols_in_use());
        send_cmd(m, p, q);
    endtask

    initial
    begin
        int burst_left;
        int rows_set;
        int cols_set;
        @(posedge rst_n);
        repeat (2) @(posedge clk);

        send_cmd(MODE_UP, 16'd0, 16'd0);
        send_cmd(MODE_DOWN, 16'hFFFF, 16'd0);
        send_cmd(MODE_FORWARD, 16'hFFFF, 16'hFFFF);
        send_cmd(MODE_BACK, 16'd0, 16'd0);
        send_cmd(MODE_BACK, 16'hFFFF, 16'd0);
        send_cmd(MODE_ADDRESS, 16'hFFFF, 16'hFFFF);
        send_cmd(MODE_ADDRESS, 16'd0, 16'd0);
        send_cmd(MODE_MARGINS, 16'd10, 16'd5);
        send_cmd(MODE_MARGINS, 16'd10, 16'd20);
        // cursor above the region: upward clamp saturates, cursor stays
        send_cmd(MODE_UP, 16'd3, 16'd0);
        send_cmd(MODE_ADDRESS, 16'd25, 16'd1);
        send_cmd(MODE_DOWN, 16'd5, 16'd0);
        send_cmd(MODE_ORIGIN_ON, 16'd0, 16'd0);
        send_cmd(MODE_REV_INDEX, 16'd0, 16'd0);
        send_cmd(MODE_ADDRESS, 16'hFFFF, 16'hFFFF);
        send_cmd(MODE_INDEX, 16'd0, 16'd0);
        send_cmd(MODE_NEXT_LINE, 16'd0, 16'd0);
        send_cmd(MODE_SAVE, 16'd0, 16'd0);
        send_cmd(MODE_ORIGIN_OFF, 16'd0, 16'd0);
        send_cmd(MODE_RESTORE, 16'd0, 16'd0);
        send_cmd(MODE_RESTORE, 16'd0, 16'd0);
        send_cmd(MODE_SOFT_RESET, 16'd0, 16'd0);
        send_cmd(MODE_SCROLL_UP, 16'd0, 16'd0);
        send_cmd(MODE_SCROLL_DOWN, 16'hFFFF, 16'd0);
        send_cmd(MODE_ADDRESS, 16'd7, 16'd9);
        send_cmd(MODE_HOME, 16'd0, 16'd0);
        send_cmd(5'd31, 16'hFFFF, 16'hFFFF);
        send_cmd(MODE_FULL_RESET, 16'd0, 16'd0);

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            if (ph > 0)
            begin
                wait_for_drain();
                rows_set = (PHASE_ROWS[ph] == 0) ? $urandom_range(3, 60) : PHASE_ROWS[ph];
                cols_set = (PHASE_COLS[ph] == 0) ? $urandom_range(3, 120) : PHASE_COLS[ph];
                write_reg(CFG_SCREEN_ROWS, 8'(rows_set));
                write_reg(CFG_SCREEN_COLS, 8'(cols_set));
            end
            rx_throttle = (ph != 1 && ph != 4);
            tx_steady = (ph == 1 || ph == 4);
            burst_left = $urandom_range(1, 16);
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                if (i == RANDOM_PER_PHASE / 2)
                begin
                    wait_for_drain();
                    // hold the result side off so the block fills and stalls
                    if (ph == 2)
                    begin
                        hold_req = 1'b1;
                    end
                end
                issue_random();
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    if (!tx_steady && $urandom_range(0, 3) != 0)
                    begin
                        idle_sender($urandom_range(1, 8));
                    end
                end
            end
        end

        wait_for_drain();
        repeat (6) @(posedge clk);
        if (sb.errors == 0 && sb.pending_count() == 0)
        begin
            $display("terminal_cursor_margin_unit_test: PASS");
        end
        else
        begin
            $display("terminal_cursor_margin_unit_test: FAIL");
        end
        $finish;
    end

endmodule
